FILE: rtl/core/psma_pkg.sv
// ----------------------------------------------------------------------------
// psma_pkg
// Shared types and constants of the per-sensor moving average block.
// ----------------------------------------------------------------------------
`default_nettype none

package psma_pkg;

    localparam int unsigned SampleW    = 16;
    localparam int unsigned KeyW       = 16;
    localparam int unsigned SlotOutW   = 4;
    localparam int unsigned WinRegW    = 7;
    localparam int unsigned MaxResults = 16;
    localparam int unsigned ResCntW    = 5;
    localparam logic [WinRegW-1:0] WinReset = 7'd8;

    typedef enum logic {
        OP_PUSH   = 1'b0,
        OP_REPORT = 1'b1
    } op_t;

    typedef enum logic {
        STS_OK   = 1'b0,
        STS_FULL = 1'b1
    } sts_t;

    typedef struct packed {
        op_t                       op;
        logic [KeyW-1:0]           key;
        logic signed [SampleW-1:0] temp;
    } item_t;

    typedef struct packed {
        sts_t                      status;
        logic [KeyW-1:0]           key;
        logic [SlotOutW-1:0]       slot;
        logic signed [SampleW-1:0] echo;
        logic signed [SampleW-1:0] mean;
        logic                      last;
    } res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK,
        ST_READ,
        ST_UPD,
        ST_DIV,
        ST_SCAN,
        ST_OUT
    } eng_state_t;

endpackage

`default_nettype wire

FILE: rtl/core/psma_queue.sv
// ----------------------------------------------------------------------------
// psma_queue
// Two-entry item queue between the input port and the engine.
// ----------------------------------------------------------------------------
`default_nettype none

module psma_queue
    import psma_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire item_t push_item,
    output logic       full,
    input  wire logic  pop,
    output logic       empty,
    output item_t      head_item
);

    item_t      entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full      = (count_reg == 2'd2);
    assign empty     = (count_reg == 2'd0);
    assign head_item = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

endmodule

`default_nettype wire

FILE: rtl/core/psma_div.sv
// ----------------------------------------------------------------------------
// psma_div
// Bit-serial signed-by-unsigned divider, quotient truncated toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module psma_div
    import psma_pkg::*;
#(
    parameter int unsigned NUM_W = 23,
    parameter int unsigned DEN_W = 7
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic signed [NUM_W-1:0]    num,
    input  wire logic [DEN_W-1:0]           den,
    output logic                            done,
    output logic signed [SampleW-1:0]       quot
);

    localparam int unsigned CntW = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W:0]   rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic             neg_reg;
    logic [CntW-1:0]  cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DEN_W:0]   rem_shift;
    logic             fits;

    assign rem_shift = {rem_reg[DEN_W-1:0], quo_reg[NUM_W-1]};
    assign fits      = (rem_shift >= {1'b0, den_reg});
    assign done      = done_reg;
    assign quot      = neg_reg ? -SampleW'(quo_reg) : SampleW'(quo_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && !start && (cnt_reg == CntW'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CntW'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CntW'(1);
                if (cnt_reg == CntW'(1))
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= num[NUM_W-1];
            quo_reg <= num[NUM_W-1] ? -num : num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? rem_shift - {1'b0, den_reg} : rem_shift;
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/psma_engine.sv
// ----------------------------------------------------------------------------
// psma_engine
// Back end: slot table, sample rings, running sums and result sequencing.
// ----------------------------------------------------------------------------
`default_nettype none

module psma_engine
    import psma_pkg::*;
#(
    parameter int unsigned MAX_SENSORS = 16,
    parameter int unsigned WINDOW_MAX  = 64
)
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 clr,
    input  wire logic [$clog2(WINDOW_MAX+1)-1:0]      win,
    input  wire logic                                 q_empty,
    input  wire item_t                                q_item,
    output logic                                      q_pop,
    output logic                                      res_valid,
    input  wire logic                                 res_ready,
    output res_t                                      res
);

    localparam int unsigned SW   = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
    localparam int unsigned FW   = $clog2(WINDOW_MAX + 1);
    localparam int unsigned HW   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int unsigned SUMW = SampleW + FW;
    localparam int unsigned MEMD = MAX_SENSORS * WINDOW_MAX;
    localparam int unsigned AW   = (MEMD > 1) ? $clog2(MEMD) : 1;

    eng_state_t state_reg, state_next;

    logic                   valid_reg [MAX_SENSORS];
    logic [KeyW-1:0]        key_reg   [MAX_SENSORS];
    logic [HW-1:0]          head_reg  [MAX_SENSORS];
    logic [FW-1:0]          fill_reg  [MAX_SENSORS];
    logic signed [SUMW-1:0] sum_reg   [MAX_SENSORS];

    logic signed [SampleW-1:0] ring_mem [MEMD];
    logic signed [SampleW-1:0] rdata_reg;

    item_t            item_reg;
    logic [SW-1:0]    slot_reg;
    logic [HW-1:0]    h_reg;
    logic [ResCntW-1:0] cnt_reg;
    res_t             res_reg;

    logic             hit, free;
    logic [SW-1:0]    hit_idx, free_idx;
    logic             any_above;
    logic [HW-1:0]    h_fix;
    logic [AW-1:0]    mem_addr;
    logic             ring_full;
    logic signed [SUMW-1:0] new_sum;
    logic [FW-1:0]    new_fill;
    logic [HW-1:0]    new_head;
    logic             rep_last;

    logic                      div_start;
    logic signed [SUMW-1:0]    div_num;
    logic [FW-1:0]             div_den;
    logic                      div_done;
    logic signed [SampleW-1:0] div_quot;

    // key match and lowest free slot
    always_comb
    begin
        hit      = 1'b0;
        free     = 1'b0;
        hit_idx  = '0;
        free_idx = '0;
        for (int s = 0; s < MAX_SENSORS; s++)
        begin
            if (valid_reg[s] && key_reg[s] == item_reg.key && !hit)
            begin
                hit     = 1'b1;
                hit_idx = SW'(s);
            end
            if (!valid_reg[s] && !free)
            begin
                free     = 1'b1;
                free_idx = SW'(s);
            end
        end
    end

    always_comb
    begin
        any_above = 1'b0;
        for (int s = 0; s < MAX_SENSORS; s++)
            if (SW'(s) > slot_reg && valid_reg[s])
                any_above = 1'b1;
    end

    assign rep_last = !any_above || (cnt_reg == ResCntW'(MaxResults - 1));

    assign h_fix     = (FW'(head_reg[slot_reg]) >= win) ? '0 : head_reg[slot_reg];
    assign mem_addr  = AW'(slot_reg) * AW'(WINDOW_MAX) + AW'(h_reg);
    assign ring_full = (fill_reg[slot_reg] >= win);
    assign new_fill  = ring_full ? win : fill_reg[slot_reg] + FW'(1);
    assign new_sum   = sum_reg[slot_reg]
                     - (ring_full ? SUMW'(rdata_reg) : '0)
                     + SUMW'(item_reg.temp);
    assign new_head  = (FW'(h_reg) + FW'(1) >= win) ? '0 : h_reg + HW'(1);

    assign div_start = (state_reg == ST_UPD)
                    || (state_reg == ST_SCAN && valid_reg[slot_reg]
                        && fill_reg[slot_reg] != '0);
    assign div_num   = (state_reg == ST_UPD) ? new_sum : sum_reg[slot_reg];
    assign div_den   = (state_reg == ST_UPD) ? new_fill : fill_reg[slot_reg];

    psma_div #(
        .NUM_W (SUMW),
        .DEN_W (FW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign q_pop     = (state_reg == ST_IDLE) && !q_empty;
    assign res_valid = (state_reg == ST_OUT);
    assign res       = res_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (!q_empty)
                    state_next = (q_item.op == OP_REPORT) ? ST_SCAN : ST_LOOK;
            ST_LOOK:
                state_next = (hit || free) ? ST_READ : ST_OUT;
            ST_READ:
                state_next = ST_UPD;
            ST_UPD:
                state_next = ST_DIV;
            ST_DIV:
                if (div_done)
                    state_next = ST_OUT;
            ST_SCAN:
                if (valid_reg[slot_reg])
                    state_next = (fill_reg[slot_reg] != '0) ? ST_DIV : ST_OUT;
                else if (slot_reg == SW'(MAX_SENSORS - 1))
                    state_next = ST_IDLE;
            ST_OUT:
                if (res_ready)
                    state_next = (item_reg.op == OP_REPORT && !res_reg.last)
                               ? ST_SCAN : ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            for (int s = 0; s < MAX_SENSORS; s++)
                valid_reg[s] <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (clr)
            begin
                for (int s = 0; s < MAX_SENSORS; s++)
                    valid_reg[s] <= 1'b0;
            end
            else if (state_reg == ST_LOOK && !hit && free)
                valid_reg[free_idx] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
                if (!q_empty)
                begin
                    item_reg <= q_item;
                    slot_reg <= '0;
                    cnt_reg  <= '0;
                end
            ST_LOOK:
            begin
                res_reg.status <= STS_FULL;
                res_reg.key    <= item_reg.key;
                res_reg.slot   <= '0;
                res_reg.echo   <= item_reg.temp;
                res_reg.mean   <= '0;
                res_reg.last   <= 1'b1;
                if (hit)
                    slot_reg <= hit_idx;
                else if (free)
                begin
                    slot_reg           <= free_idx;
                    key_reg[free_idx]  <= item_reg.key;
                    head_reg[free_idx] <= '0;
                    fill_reg[free_idx] <= '0;
                    sum_reg[free_idx]  <= '0;
                end
            end
            ST_READ:
            begin
                h_reg     <= h_fix;
                rdata_reg <= ring_mem[AW'(slot_reg) * AW'(WINDOW_MAX) + AW'(h_fix)];
            end
            ST_UPD:
            begin
                ring_mem[mem_addr] <= item_reg.temp;
                sum_reg[slot_reg]  <= new_sum;
                fill_reg[slot_reg] <= new_fill;
                head_reg[slot_reg] <= new_head;
                res_reg.status     <= STS_OK;
                res_reg.slot       <= SlotOutW'(slot_reg);
            end
            ST_DIV:
                if (div_done)
                    res_reg.mean <= div_quot;
            ST_SCAN:
                if (valid_reg[slot_reg])
                begin
                    res_reg.status <= STS_OK;
                    res_reg.key    <= key_reg[slot_reg];
                    res_reg.slot   <= SlotOutW'(slot_reg);
                    res_reg.echo   <= '0;
                    res_reg.mean   <= '0;
                    res_reg.last   <= rep_last;
                end
                else if (slot_reg != SW'(MAX_SENSORS - 1))
                    slot_reg <= slot_reg + SW'(1);
            ST_OUT:
                if (res_ready && item_reg.op == OP_REPORT && !res_reg.last)
                begin
                    slot_reg <= slot_reg + SW'(1);
                    cnt_reg  <= cnt_reg + ResCntW'(1);
                end
            default:
                ;
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/core/per_sensor_moving_average.sv
// ----------------------------------------------------------------------------
// per_sensor_moving_average
// Multi-sensor moving average of Q8.8 temperature samples.
// ----------------------------------------------------------------------------
// A push transfer (op 0) looks its sensor_key up in a table of MAX_SENSORS
// slots, claims the lowest free slot for a new key, stores the sample in
// that slot's ring and returns one result with the sample and the mean of
// the stored samples (sum / count, truncated toward zero). With no free
// slot it returns status 1 and stores nothing. A report transfer (op 1)
// returns one result per used slot in slot order, the final one with last
// set; up to 16 results. Inputs go into a two-entry queue, so the block
// takes new transfers while a result still waits on out_stall. A push
// goes through queue pop, table lookup, ring read, update, the bit-serial
// divider that takes one sum bit per cycle and the hand-off to the output
// register; the sum is SUMW = 16 + clog2(WINDOW_MAX+1) bits wide, 23 at the
// default. A table full push skips the ring read, update and divider. A
// report runs the divider for each used slot and skips unused slots.
// Writing window_size (byte address 0) clears every slot; values are clamped
// to 1..WINDOW_MAX.
// ----------------------------------------------------------------------------
`default_nettype none

module per_sensor_moving_average
    import psma_pkg::*;
#(
    parameter int unsigned MAX_SENSORS = 16,
    parameter int unsigned WINDOW_MAX  = 64
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    // APB config port
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [2:0]                paddr,
    input  wire logic [31:0]               pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    // input channel
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic                      op,
    input  wire logic [KeyW-1:0]           sensor_key,
    input  wire logic signed [SampleW-1:0] temperature,
    // result channel
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic                           status,
    output logic [KeyW-1:0]                result_key,
    output logic [SlotOutW-1:0]            slot_index,
    output logic signed [SampleW-1:0]      sample_echo,
    output logic signed [SampleW-1:0]      mean_value,
    output logic                           last
);

    localparam int unsigned FW = $clog2(WINDOW_MAX + 1);
    localparam logic [2:0]  AddrWin = 3'd0;

    logic [WinRegW-1:0] win_reg;
    logic [FW-1:0]      win_eff;
    logic               cfg_wr;

    logic   q_full, q_empty, q_pop, q_push;
    item_t  q_in, q_head;

    logic   res_valid, res_ready;
    res_t   res;
    res_t   out_reg;
    logic   out_valid_reg;

    // config register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == AddrWin);
    assign prdata = (paddr == AddrWin) ? {{(32 - WinRegW){1'b0}}, win_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            win_reg <= WinReset;
        else if (cfg_wr)
            win_reg <= pwdata[WinRegW-1:0];
    end

    // effective window: zero acts as one, capped at WINDOW_MAX
    always_comb
    begin
        if (win_reg == '0)
            win_eff = FW'(1);
        else if (32'(win_reg) > 32'(WINDOW_MAX))
            win_eff = FW'(WINDOW_MAX);
        else
            win_eff = FW'(win_reg);
    end

    // front: input queue
    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;
    assign q_in     = '{op: op_t'(op), key: sensor_key, temp: temperature};

    psma_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head_item (q_head)
    );

    // back: table, rings and divider
    psma_engine #(
        .MAX_SENSORS (MAX_SENSORS),
        .WINDOW_MAX  (WINDOW_MAX)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .clr       (cfg_wr),
        .win       (win_eff),
        .q_empty   (q_empty),
        .q_item    (q_head),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // output register
    assign res_ready = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_ready)
            out_valid_reg <= res_valid;
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
            out_reg <= res;
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_reg.status;
    assign result_key  = out_reg.key;
    assign slot_index  = out_reg.slot;
    assign sample_echo = out_reg.echo;
    assign mean_value  = out_reg.mean;
    assign last        = out_reg.last;

endmodule

`default_nettype wire
